[rtl/rsd_pkg.sv]
// Shared types and constants of the run-length sprite decoder.
`default_nettype none

package rsd_pkg;

   localparam int RSD_CSR_INDEX_WIDTH = 2;
   localparam int RSD_CSR_DATA_WIDTH  = 8;

   typedef enum logic [RSD_CSR_INDEX_WIDTH-1:0] {
      CSR_SPRITE_SIDE = 2'd0,
      CSR_ALPHA_MODE  = 2'd1
   } csr_index_type;

   localparam logic [7:0] RSD_SIDE_RESET   = 8'd32;
   localparam logic [7:0] RSD_ALPHA_OPAQUE = 8'hFF;
   localparam logic [2:0] RSD_TALLY_MAX    = 3'd5;
   localparam logic [2:0] RSD_TALLY_FLAG   = 3'd4;
   localparam int         RSD_QUEUE_DEPTH  = 4;

   typedef struct packed {
      logic [31:0] pixel_rgba;
      logic [14:0] run_length;
      logic        has_transparency;
      logic        last_of_sprite;
   } rsd_result_type;

   // One decoded byte can produce a run (transparent or colored pixel)
   // followed by the transparent padding run.
   typedef struct packed {
      logic           slot0_valid;
      rsd_result_type slot0;
      logic           slot1_valid;
      rsd_result_type slot1;
   } rsd_entry_type;

endpackage

`default_nettype wire

[rtl/rsd_channels.sv]
// Channel interfaces of the run-length sprite decoder: request, response, register writes.
`default_nettype none

interface rsd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] total_bytes;
   logic        first_byte;

   modport source (output valid, data_byte, total_bytes, first_byte, input ready);
   modport sink   (input valid, data_byte, total_bytes, first_byte, output ready);
endinterface

interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_rgba;
   logic [14:0] run_length;
   logic        has_transparency;
   logic        last_of_sprite;

   modport source  (output valid, pixel_rgba, run_length, has_transparency, last_of_sprite,
                    input ready);
   modport sink    (input valid, pixel_rgba, run_length, has_transparency, last_of_sprite,
                    output ready);
   modport monitor (input valid, ready, pixel_rgba, run_length, has_transparency,
                    last_of_sprite);
endinterface

interface rsd_csr_if;
   import rsd_pkg::*;
   logic                           valid;
   logic                           ready;
   logic [RSD_CSR_INDEX_WIDTH-1:0] index;
   logic [RSD_CSR_DATA_WIDTH-1:0]  write_data;

   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

`default_nettype wire

[rtl/rsd_front.sv]
// Front end: register file, byte-by-byte decoding state and result classification.
`default_nettype none

module rsd_front #(
   parameter int MAX_SIDE  = 128,
   parameter int MAX_BLOCK = 4096
) (
   input  wire                   clock,
   input  wire                   reset,
   rsd_req_if.sink               req_bus,
   rsd_csr_if.sink               csr_bus,
   input  wire                   queue_full,
   output logic                  push,
   output rsd_pkg::rsd_entry_type push_entry
);
   import rsd_pkg::*;

   localparam int MAX_PIXELS = MAX_SIDE * MAX_SIDE;
   localparam int PW_WIDTH   = $clog2(MAX_PIXELS + 1);
   localparam int CL_WIDTH   = $clog2(MAX_BLOCK + 1);
   localparam int ADD_WIDTH  = (PW_WIDTH > 16) ? PW_WIDTH : 16;
   localparam int SUM_WIDTH  = ADD_WIDTH + 1;
   localparam int CB_WIDTH   = CL_WIDTH + 2;
   localparam int BS_WIDTH   = ((CB_WIDTH > 16) ? CB_WIDTH : 16) + 1;
   localparam int RESET_PIXELS = 32 * 32;

   localparam logic [2:0] PHASE_HEADER0    = 3'd0;
   localparam logic [2:0] PHASE_HEADER_END = 3'd3;
   localparam logic [2:0] PHASE_PIXEL0     = 3'd4;

   logic [PW_WIDTH-1:0] px_total_ff, px_total_in;
   logic                alpha_mode_ff, alpha_mode_in;

   logic [15:0]         byte_index_ff, byte_index_in;
   logic [2:0]          phase_ff, phase_in;
   logic [23:0]         header_shift_ff, header_shift_in;
   logic [CL_WIDTH-1:0] colored_left_ff, colored_left_in;
   logic [23:0]         pixel_assembly_ff, pixel_assembly_in;
   logic [PW_WIDTH-1:0] pixels_written_ff, pixels_written_in;
   logic [2:0]          tally_ff, tally_in;
   logic                alpha_seen_ff, alpha_seen_in;
   logic                halted_ff, halted_in;

   logic                accept;
   logic                csr_write;
   logic [8:0]          side_clamped;
   logic [17:0]         side_square;
   rsd_entry_type       entry;

   function automatic logic [2:0] tally_add(input logic [2:0] tally,
                                            input logic [ADD_WIDTH-1:0] amount);
      logic [2:0] step;
      logic [3:0] sum;
      step = (amount > ADD_WIDTH'(RSD_TALLY_MAX)) ? RSD_TALLY_MAX : amount[2:0];
      sum  = {1'b0, tally} + {1'b0, step};
      return (sum > {1'b0, RSD_TALLY_MAX}) ? RSD_TALLY_MAX : sum[2:0];
   endfunction

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !queue_full;
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   // Side zero counts as one, anything above the limit as the limit.
   always_comb begin
      if (csr_bus.write_data == '0) begin
         side_clamped = 9'd1;
      end else if ({1'b0, csr_bus.write_data} > 9'(MAX_SIDE)) begin
         side_clamped = 9'(MAX_SIDE);
      end else begin
         side_clamped = {1'b0, csr_bus.write_data};
      end
      side_square = side_clamped * side_clamped;
   end

   always_comb begin
      px_total_in   = px_total_ff;
      alpha_mode_in = alpha_mode_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_SPRITE_SIDE: px_total_in   = PW_WIDTH'(side_square);
            CSR_ALPHA_MODE:  alpha_mode_in = csr_bus.write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [15:0]          bi;
      logic [2:0]           ph;
      logic [23:0]          hs;
      logic [CL_WIDTH-1:0]  cl;
      logic [23:0]          pa;
      logic [PW_WIDTH-1:0]  pw;
      logic [2:0]           tl;
      logic                 aseen;
      logic                 hl;
      logic                 pad_due;
      logic                 last;
      logic [15:0]          t;
      logic [15:0]          c_raw;
      logic [CL_WIDTH-1:0]  c;
      logic [CB_WIDTH-1:0]  c_bytes;
      logic [SUM_WIDTH-1:0] pw_sum;
      logic [1:0]           k;
      logic                 done;
      logic [7:0]           alpha;
      logic [PW_WIDTH-1:0]  rem;

      bi    = byte_index_ff;
      ph    = phase_ff;
      hs    = header_shift_ff;
      cl    = colored_left_ff;
      pa    = pixel_assembly_ff;
      pw    = pixels_written_ff;
      tl    = tally_ff;
      aseen = alpha_seen_ff;
      hl    = halted_ff;
      pad_due = 1'b0;
      entry   = '0;
      last    = 1'b0;
      t       = '0;
      c_raw   = '0;
      c       = '0;
      c_bytes = '0;
      pw_sum  = '0;
      k       = '0;
      done    = 1'b0;
      alpha   = '0;
      rem     = '0;

      if (req_bus.first_byte) begin
         bi    = '0;
         ph    = PHASE_HEADER0;
         hs    = '0;
         cl    = '0;
         pa    = '0;
         pw    = '0;
         tl    = '0;
         aseen = 1'b0;
         hl    = 1'b0;
      end

      if (!hl) begin
         if (bi >= req_bus.total_bytes) begin
            pad_due = 1'b1;
         end else begin
            bi = bi + 16'd1;
            if (ph < PHASE_HEADER_END) begin
               case (ph[1:0])
                  2'd0:    hs[7:0]   = hs[7:0]   | req_bus.data_byte;
                  2'd1:    hs[15:8]  = hs[15:8]  | req_bus.data_byte;
                  default: hs[23:16] = hs[23:16] | req_bus.data_byte;
               endcase
               ph = ph + 3'd1;
            end else if (ph == PHASE_HEADER_END) begin
               t     = hs[15:0];
               c_raw = {req_bus.data_byte, hs[23:16]};
               hs    = '0;
               ph    = PHASE_HEADER0;
               tl    = tally_add(tl, ADD_WIDTH'(t));
               pw_sum = SUM_WIDTH'(pw) + SUM_WIDTH'(t);
               if (pw_sum > SUM_WIDTH'(px_total_ff)) begin
                  pad_due = 1'b1;
               end else begin
                  last = 1'b0;
                  if (t != '0) begin
                     pw   = PW_WIDTH'(pw_sum);
                     last = (pw >= px_total_ff);
                     entry.slot0_valid            = 1'b1;
                     entry.slot0.pixel_rgba       = '0;
                     entry.slot0.run_length       = 15'(t);
                     entry.slot0.last_of_sprite   = last;
                     entry.slot0.has_transparency = last && (aseen || tl > RSD_TALLY_FLAG);
                     hl = last;
                  end
                  if (!last) begin
                     c = (c_raw > 16'(MAX_BLOCK)) ? CL_WIDTH'(MAX_BLOCK) : CL_WIDTH'(c_raw);
                     c_bytes = alpha_mode_ff ? {c, 2'b00}
                                             : ({2'b00, c} + {1'b0, c, 1'b0});
                     if (BS_WIDTH'(bi) + BS_WIDTH'(c_bytes) > BS_WIDTH'(req_bus.total_bytes))
                        begin
                        pad_due = 1'b1;
                     end else begin
                        cl = c;
                        pa = '0;
                        if (c != '0) begin
                           ph = PHASE_PIXEL0;
                        end
                        pad_due = (bi >= req_bus.total_bytes);
                     end
                  end
               end
            end else begin
               k = ph[1:0];
               case (k)
                  2'd0:    pa[7:0]   = pa[7:0]   | req_bus.data_byte;
                  2'd1:    pa[15:8]  = pa[15:8]  | req_bus.data_byte;
                  2'd2:    pa[23:16] = pa[23:16] | req_bus.data_byte;
                  default: ;
               endcase
               done = alpha_mode_ff ? (k == 2'd3) : (k >= 2'd2);
               if (!done) begin
                  ph = ph + 3'd1;
               end else begin
                  alpha = alpha_mode_ff ? req_bus.data_byte : RSD_ALPHA_OPAQUE;
                  if (alpha != RSD_ALPHA_OPAQUE) begin
                     aseen = 1'b1;
                  end
                  pw = pw + PW_WIDTH'(1);
                  if (cl != '0) begin
                     cl = cl - CL_WIDTH'(1);
                  end
                  last = (pw >= px_total_ff);
                  entry.slot0_valid            = 1'b1;
                  entry.slot0.pixel_rgba       = {alpha, pa};
                  entry.slot0.run_length       = 15'd1;
                  entry.slot0.last_of_sprite   = last;
                  entry.slot0.has_transparency = last && (aseen || tl > RSD_TALLY_FLAG);
                  pa = '0;
                  if (last) begin
                     hl = 1'b1;
                  end else begin
                     ph = (cl != '0) ? PHASE_PIXEL0 : PHASE_HEADER0;
                     pad_due = (bi >= req_bus.total_bytes);
                  end
               end
            end
            // The byte that uses up the data ends the sprite, whatever part it belonged to.
            if (!hl && bi >= req_bus.total_bytes) begin
               pad_due = 1'b1;
            end
         end
      end

      // Fill the rest of the image with one transparent run and stop.
      if (pad_due) begin
         if (pw < px_total_ff) begin
            rem = px_total_ff - pw;
            tl  = tally_add(tl, ADD_WIDTH'(rem));
            pw  = px_total_ff;
            entry.slot1_valid            = 1'b1;
            entry.slot1.pixel_rgba       = '0;
            entry.slot1.run_length       = 15'(rem);
            entry.slot1.last_of_sprite   = 1'b1;
            entry.slot1.has_transparency = aseen || tl > RSD_TALLY_FLAG;
         end
         hl = 1'b1;
      end

      byte_index_in     = bi;
      phase_in          = ph;
      header_shift_in   = hs;
      colored_left_in   = cl;
      pixel_assembly_in = pa;
      pixels_written_in = pw;
      tally_in          = tl;
      alpha_seen_in     = aseen;
      halted_in         = hl;
   end

   assign push       = accept && (entry.slot0_valid || entry.slot1_valid);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_total_ff   <= PW_WIDTH'(RESET_PIXELS);
         alpha_mode_ff <= 1'b0;
      end else begin
         px_total_ff   <= px_total_in;
         alpha_mode_ff <= alpha_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= '0;
         phase_ff          <= PHASE_HEADER0;
         header_shift_ff   <= '0;
         colored_left_ff   <= '0;
         pixel_assembly_ff <= '0;
         pixels_written_ff <= '0;
         tally_ff          <= '0;
         alpha_seen_ff     <= 1'b0;
         halted_ff         <= 1'b0;
      end else if (accept) begin
         byte_index_ff     <= byte_index_in;
         phase_ff          <= phase_in;
         header_shift_ff   <= header_shift_in;
         colored_left_ff   <= colored_left_in;
         pixel_assembly_ff <= pixel_assembly_in;
         pixels_written_ff <= pixels_written_in;
         tally_ff          <= tally_in;
         alpha_seen_ff     <= alpha_seen_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rsd_queue.sv]
// Short FIFO of decoded result entries between the front and back ends.
`default_nettype none

module rsd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  rsd_pkg::rsd_entry_type push_entry,
   output logic                   full,
   input  wire                    pop,
   output rsd_pkg::rsd_entry_type head_entry,
   output logic                   empty
);
   import rsd_pkg::*;

   localparam int PTR_WIDTH = $clog2(RSD_QUEUE_DEPTH);

   rsd_entry_type        store_ff [RSD_QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_WIDTH:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_WIDTH+1)'(RSD_QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_WIDTH+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_WIDTH+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rsd_back.sv]
// Back end: splits queue entries into single runs and holds them in the output register.
`default_nettype none

module rsd_back (
   input  wire                    clock,
   input  wire                    reset,
   input  rsd_pkg::rsd_entry_type head_entry,
   input  wire                    empty,
   output logic                   pop,
   rsd_rsp_if.source              rsp_bus
);
   import rsd_pkg::*;

   logic           slot_sel_ff, slot_sel_in;
   logic           valid_ff, valid_in;
   rsd_result_type result_ff;
   logic           use_slot1;
   logic           more;
   logic           load;
   rsd_result_type current;

   // Slot zero goes first when present; the padding slot follows.
   assign use_slot1 = slot_sel_ff || !head_entry.slot0_valid;
   assign current   = use_slot1 ? head_entry.slot1 : head_entry.slot0;
   assign more      = !use_slot1 && head_entry.slot1_valid;
   assign load      = !empty && (!valid_ff || rsp_bus.ready);
   assign pop       = load && !more;

   always_comb begin
      slot_sel_in = slot_sel_ff;
      valid_in    = valid_ff;
      if (load) begin
         slot_sel_in = more;
         valid_in    = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_sel_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         slot_sel_ff <= slot_sel_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= current;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.pixel_rgba       = result_ff.pixel_rgba;
   assign rsp_bus.run_length       = result_ff.run_length;
   assign rsp_bus.has_transparency = result_ff.has_transparency;
   assign rsp_bus.last_of_sprite   = result_ff.last_of_sprite;

endmodule

`default_nettype wire

[rtl/rle_sprite_decoder.sv]
// Top level of the run-length sprite decoder: bytes in, RGBA runs out.
// Throughput: one data byte per cycle while the queue is not full; results leave at one per
// cycle through the output register while the response channel is ready. A result is registered
// in the queue, then in the output register; a second result of the same byte follows it.
// Input stalls only when the four-entry queue between front and back end is full.
// Reset (synchronous): decoding state cleared, sprite_side 32, alpha_mode 0, queue empty.
`default_nettype none

module rle_sprite_decoder #(
   parameter int MAX_SIDE  = 128,
   parameter int MAX_BLOCK = 4096
) (
   input  wire        clock,
   input  wire        reset,
   rsd_req_if.sink    req_bus,
   rsd_rsp_if.source  rsp_bus,
   rsd_csr_if.sink    csr_bus
);
   import rsd_pkg::*;

   // The front end decodes one byte per transaction and classifies what it
   // produces: nothing (header or partial pixel bytes), a transparent run or
   // a finished pixel, and possibly the padding run that fills the image.
   // Those results travel as one queue entry, so the front end never waits
   // on a two-result byte.
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;
   rsd_entry_type push_entry;
   rsd_entry_type head_entry;

   rsd_front #(
      .MAX_SIDE  (MAX_SIDE),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // The queue decouples the two ends so a stalled response channel does not
   // stop byte intake until four entries are waiting.
   rsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   // The back end hands out one run per response transaction, in order.
   rsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

[rtl/rsd_checker.sv]
// Port-level checks of the run-length sprite decoder and their binding to the top level.
`default_nettype none

module rsd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_pixel_rgba,
   input wire [14:0] rsp_run_length,
   input wire        rsp_has_transparency,
   input wire        rsp_last_of_sprite
);

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_pixel_rgba) && $stable(rsp_run_length)
         && $stable(rsp_last_of_sprite) && $stable(rsp_has_transparency))
      else $error("response changed while stalled");

   rsp_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   flag_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_transparency |-> rsp_last_of_sprite)
      else $error("transparency flag on a run that does not end the sprite");

   colored_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_rgba[31:24] != 8'd0 |-> rsp_run_length == 15'd1)
      else $error("colored pixel run longer than one");

endmodule

bind rle_sprite_decoder rsd_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_pixel_rgba       (rsp_bus.pixel_rgba),
   .rsp_run_length       (rsp_bus.run_length),
   .rsp_has_transparency (rsp_bus.has_transparency),
   .rsp_last_of_sprite   (rsp_bus.last_of_sprite)
);

`default_nettype wire
